>>> sv/sorted_expiry_timer_queue_macros.svh
// Assertion macros used by the checker file of the timer queue.
`ifndef SORTED_EXPIRY_TIMER_QUEUE_MACROS_SVH
`define SORTED_EXPIRY_TIMER_QUEUE_MACROS_SVH

// Checked only while reset is released.
`define SETQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("timer queue assertion failed");

// Checked at every edge, reset included.
`define SETQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("timer queue assertion failed");

`endif

>>> sv/setq_pkg.sv
package setq_pkg;

  localparam int HANDLE_W = 8;
  localparam int TIME_W = 32;
  localparam int KIND_W = 2;
  localparam int STATUS_W = 2;
  localparam int CAPACITY_DEF = 16;
  localparam int MAX_RESULTS = 16;
  localparam int POP_W = $clog2(MAX_RESULTS);

  localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADJUST = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_INSERT,
    S_POP
  } setq_state_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_POP
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   stamp;
  } setq_cmd_t;

  typedef struct packed {
    logic                found;
    logic                head_due;
    logic                next_due;
    logic [HANDLE_W-1:0] head_handle;
  } setq_stat_t;

endpackage

>>> sv/setq_cell.sv
module setq_cell (
  input  logic                           clk_i,
  input  setq_pkg::setq_cmd_t            cmd_i,
  input  logic                           valid_i,
  input  logic [setq_pkg::HANDLE_W-1:0]  left_handle_i,
  input  logic [setq_pkg::TIME_W-1:0]    left_expiry_i,
  input  logic                           left_le_i,
  input  logic [setq_pkg::HANDLE_W-1:0]  right_handle_i,
  input  logic [setq_pkg::TIME_W-1:0]    right_expiry_i,
  input  logic                           chain_i,
  output logic [setq_pkg::HANDLE_W-1:0]  handle_o,
  output logic [setq_pkg::TIME_W-1:0]    expiry_o,
  output logic                           le_o,
  output logic                           match_o,
  output logic                           chain_o
);
  import setq_pkg::*;

  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic [TIME_W-1:0]   expiry_q, expiry_d;

  assign le_o     = valid_i && (expiry_q <= cmd_i.stamp);
  assign match_o  = valid_i && (handle_q == cmd_i.handle);
  assign chain_o  = chain_i | match_o;
  assign handle_o = handle_q;
  assign expiry_o = expiry_q;

  // Entries at or after the insert point move one place toward the tail;
  // entries after a removed one, and every entry on a pop, move one place toward the head.
  always_comb begin
    handle_d = handle_q;
    expiry_d = expiry_q;
    unique case (cmd_i.op)
      CELL_HOLD: begin
      end
      CELL_INSERT: begin
        if (!le_o) begin
          if (left_le_i) begin
            handle_d = cmd_i.handle;
            expiry_d = cmd_i.stamp;
          end else begin
            handle_d = left_handle_i;
            expiry_d = left_expiry_i;
          end
        end
      end
      CELL_REMOVE: begin
        if (chain_o) begin
          handle_d = right_handle_i;
          expiry_d = right_expiry_i;
        end
      end
      CELL_POP: begin
        handle_d = right_handle_i;
        expiry_d = right_expiry_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    handle_q <= handle_d;
    expiry_q <= expiry_d;
  end

endmodule

>>> sv/setq_ctrl.sv
module setq_ctrl #(
  parameter int Capacity = setq_pkg::CAPACITY_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [setq_pkg::KIND_W-1:0]    kind_i,
  input  logic [setq_pkg::HANDLE_W-1:0]  timer_handle_i,
  input  logic [setq_pkg::TIME_W-1:0]    expiry_time_i,
  input  logic [setq_pkg::TIME_W-1:0]    now_time_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [setq_pkg::HANDLE_W-1:0]  expired_handle_o,
  output logic                           has_expired_o,
  output logic [setq_pkg::STATUS_W-1:0]  status_o,
  output logic                           last_of_run_o,
  input  setq_pkg::setq_stat_t           stat_i,
  output setq_pkg::setq_cmd_t            cmd_o,
  output logic [$clog2(Capacity+1)-1:0]  count_o
);
  import setq_pkg::*;

  localparam int CntW = $clog2(Capacity + 1);

  setq_state_e state_q, state_d;

  logic [KIND_W-1:0]   kind_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [TIME_W-1:0]   expiry_q;
  logic [TIME_W-1:0]   now_q;
  logic [CntW-1:0]     count_q, count_d;
  logic [POP_W-1:0]    pops_q, pops_d;

  logic                out_valid_q;
  logic [HANDLE_W-1:0] out_handle_q;
  logic                out_has_q;
  logic [STATUS_W-1:0] out_status_q;
  logic                out_last_q;

  logic                out_free;
  logic                full;
  logic                emit;
  logic [HANDLE_W-1:0] e_handle;
  logic                e_has;
  logic [STATUS_W-1:0] e_status;
  logic                e_last;

  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = (count_q == CntW'(Capacity));
  assign count_o  = count_q;

  always_comb begin
    cmd_o.op     = CELL_HOLD;
    cmd_o.handle = handle_q;
    cmd_o.stamp  = (kind_q == KIND_TICK) ? now_q : expiry_q;
    count_d      = count_q;
    pops_d       = pops_q;
    emit         = 1'b0;
    e_handle     = '0;
    e_has        = 1'b0;
    e_status     = STATUS_OK;
    e_last       = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        pops_d = '0;
      end
      S_EXEC: begin
        unique case (kind_q)
          KIND_ADD: begin
            if (out_free) begin
              emit = 1'b1;
              if (stat_i.found) begin
                e_status = STATUS_DUPLICATE;
              end else if (full) begin
                e_status = STATUS_FULL;
              end else begin
                cmd_o.op = CELL_INSERT;
                count_d  = count_q + CntW'(1);
              end
            end
          end
          KIND_ADJUST: begin
            if (stat_i.found) begin
              cmd_o.op = CELL_REMOVE;
              count_d  = count_q - CntW'(1);
            end else if (out_free) begin
              emit     = 1'b1;
              e_status = STATUS_NOT_FOUND;
            end
          end
          KIND_DELETE: begin
            if (out_free) begin
              emit = 1'b1;
              if (stat_i.found) begin
                cmd_o.op = CELL_REMOVE;
                count_d  = count_q - CntW'(1);
              end else begin
                e_status = STATUS_NOT_FOUND;
              end
            end
          end
          KIND_TICK: begin
          end
          default: begin
          end
        endcase
      end
      S_INSERT: begin
        if (out_free) begin
          emit     = 1'b1;
          cmd_o.op = CELL_INSERT;
          count_d  = count_q + CntW'(1);
        end
      end
      S_POP: begin
        if (out_free) begin
          emit = 1'b1;
          if (stat_i.head_due) begin
            cmd_o.op = CELL_POP;
            count_d  = count_q - CntW'(1);
            pops_d   = pops_q + POP_W'(1);
            e_handle = stat_i.head_handle;
            e_has    = 1'b1;
            e_last   = (pops_q == POP_W'(MAX_RESULTS - 1)) || !stat_i.next_due;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (kind_q == KIND_TICK) begin
          state_d = S_POP;
        end else if ((kind_q == KIND_ADJUST) && stat_i.found) begin
          state_d = S_INSERT;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_INSERT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        if (emit && e_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pops_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pops_q  <= pops_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      kind_q   <= kind_i;
      handle_q <= timer_handle_i;
      expiry_q <= expiry_time_i;
      now_q    <= now_time_i;
    end
    if (emit) begin
      out_handle_q <= e_handle;
      out_has_q    <= e_has;
      out_status_q <= e_status;
      out_last_q   <= e_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign expired_handle_o = out_handle_q;
  assign has_expired_o    = out_has_q;
  assign status_o         = out_status_q;
  assign last_of_run_o    = out_last_q;

endmodule

>>> sv/sorted_expiry_timer_queue.sv
// An add or delete word, or an adjust whose handle is not found, gives its result from the exec state.
// An adjust that finds its handle gives its result from the insert state, a tick its first from the pop state.
// A tick then gives one more expired handle per cycle while the output is not stalled.
// The input is stalled until the sequencer is back in idle, so a new word waits for the last to finish;
// the single shared command bus that drives the row of cells sets the pace.
// Reset clears the entry count, the sequencer and the output valid; cell contents are not cleared.
module sorted_expiry_timer_queue #(
  parameter int Capacity = setq_pkg::CAPACITY_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [setq_pkg::KIND_W-1:0]    kind_i,
  input  logic [setq_pkg::HANDLE_W-1:0]  timer_handle_i,
  input  logic [setq_pkg::TIME_W-1:0]    expiry_time_i,
  input  logic [setq_pkg::TIME_W-1:0]    now_time_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [setq_pkg::HANDLE_W-1:0]  expired_handle_o,
  output logic                           has_expired_o,
  output logic [setq_pkg::STATUS_W-1:0]  status_o,
  output logic                           last_of_run_o
);
  import setq_pkg::*;

  localparam int CntW = $clog2(Capacity + 1);

  setq_cmd_t           cmd;
  setq_stat_t          stat;
  logic [CntW-1:0]     count;

  logic [HANDLE_W-1:0] handle_a [Capacity];
  logic [TIME_W-1:0]   expiry_a [Capacity];
  logic [Capacity-1:0] le_a;
  logic [Capacity-1:0] match_a;
  logic [Capacity-1:0] chain_a;

  setq_ctrl #(
    .Capacity (Capacity)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .timer_handle_i   (timer_handle_i),
    .expiry_time_i    (expiry_time_i),
    .now_time_i       (now_time_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .expired_handle_o (expired_handle_o),
    .has_expired_o    (has_expired_o),
    .status_o         (status_o),
    .last_of_run_o    (last_of_run_o),
    .stat_i           (stat),
    .cmd_o            (cmd),
    .count_o          (count)
  );

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [HANDLE_W-1:0] left_handle;
    logic [TIME_W-1:0]   left_expiry;
    logic                left_le;
    logic                chain_in;
    logic [HANDLE_W-1:0] right_handle;
    logic [TIME_W-1:0]   right_expiry;

    if (i == 0) begin : g_head
      assign left_handle = handle_a[i];
      assign left_expiry = expiry_a[i];
      assign left_le     = 1'b1;
      assign chain_in    = 1'b0;
    end else begin : g_body
      assign left_handle = handle_a[i-1];
      assign left_expiry = expiry_a[i-1];
      assign left_le     = le_a[i-1];
      assign chain_in    = chain_a[i-1];
    end

    if (i == Capacity - 1) begin : g_tail
      assign right_handle = handle_a[i];
      assign right_expiry = expiry_a[i];
    end else begin : g_inner
      assign right_handle = handle_a[i+1];
      assign right_expiry = expiry_a[i+1];
    end

    setq_cell u_cell (
      .clk_i          (clk_i),
      .cmd_i          (cmd),
      .valid_i        (count > CntW'(i)),
      .left_handle_i  (left_handle),
      .left_expiry_i  (left_expiry),
      .left_le_i      (left_le),
      .right_handle_i (right_handle),
      .right_expiry_i (right_expiry),
      .chain_i        (chain_in),
      .handle_o       (handle_a[i]),
      .expiry_o       (expiry_a[i]),
      .le_o           (le_a[i]),
      .match_o        (match_a[i]),
      .chain_o        (chain_a[i])
    );
  end

  assign stat.found       = |match_a;
  assign stat.head_due    = le_a[0];
  assign stat.next_due    = le_a[1];
  assign stat.head_handle = handle_a[0];

endmodule

>>> sv/setq_chk.sv
`include "sorted_expiry_timer_queue_macros.svh"

module setq_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [setq_pkg::KIND_W-1:0]    kind_i,
  input logic [setq_pkg::HANDLE_W-1:0]  timer_handle_i,
  input logic [setq_pkg::TIME_W-1:0]    expiry_time_i,
  input logic [setq_pkg::TIME_W-1:0]    now_time_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [setq_pkg::HANDLE_W-1:0]  expired_handle_o,
  input logic                           has_expired_o,
  input logic [setq_pkg::STATUS_W-1:0]  status_o,
  input logic                           last_of_run_o
);
  import setq_pkg::*;

  // An accepted word keeps the input closed for at least the next cycle.
  `SETQ_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)

  // A word without an expired handle carries handle zero and ends its run.
  `SETQ_ASSERT(a_idle_word_shape, clk_i, rst_ni, (out_valid_o && !has_expired_o) |-> ((expired_handle_o == '0) && last_of_run_o))

  // Expired handles only come with an ok status.
  `SETQ_ASSERT(a_expired_ok, clk_i, rst_ni, (out_valid_o && has_expired_o) |-> (status_o == STATUS_OK))

  // A stalled result word holds.
  `SETQ_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(expired_handle_o) && $stable(status_o) && $stable(last_of_run_o)))

  // A cycle spent in reset leaves no result word shown after it.
  `SETQ_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o)

endmodule

bind sorted_expiry_timer_queue setq_chk u_setq_chk (.*);

>>> test/tb_top.sv
module tb_top;
  import setq_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int POOL_SIZE = 20;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [HANDLE_W-1:0] handle;
    logic                expired;
    logic [STATUS_W-1:0] status;
    logic                last;
  } outcome_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   kind = KIND_TICK;
  logic [HANDLE_W-1:0] timer_handle = '0;
  logic [TIME_W-1:0]   expiry_time = '0;
  logic [TIME_W-1:0]   now_time = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [HANDLE_W-1:0] expired_handle;
  logic                has_expired;
  logic [STATUS_W-1:0] status;
  logic                last_of_run;

  logic [HANDLE_W-1:0] shadow_handle [CAP];
  logic [TIME_W-1:0]   shadow_expiry [CAP];
  int                  shadow_count = 0;

  outcome_t            outcome_q [$];
  outcome_t            oldest;
  logic [HANDLE_W-1:0] handle_pool [POOL_SIZE];
  logic [TIME_W-1:0]   time_cursor = '0;
  logic [TIME_W-1:0]   recent_expiry = '0;

  int  errors = 0;
  int  words_sent = 0;
  int  results_seen = 0;
  int  expired_seen = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;
  int  stall_left = 0;
  int  free_left = 0;

  sorted_expiry_timer_queue dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .kind_i          (kind),
    .timer_handle_i  (timer_handle),
    .expiry_time_i   (expiry_time),
    .now_time_i      (now_time),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .expired_handle_o(expired_handle),
    .has_expired_o   (has_expired),
    .status_o        (status),
    .last_of_run_o   (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic drop_entry(input int pos);
    for (int i = pos; i + 1 < shadow_count; i++) begin
      shadow_handle[i] = shadow_handle[i + 1];
      shadow_expiry[i] = shadow_expiry[i + 1];
    end
    shadow_count--;
  endtask

  task automatic place_entry(input logic [HANDLE_W-1:0] h, input logic [TIME_W-1:0] t);
    int pos;
    pos = 0;
    while (pos < shadow_count && shadow_expiry[pos] <= t) pos++;
    for (int i = shadow_count; i > pos; i--) begin
      shadow_handle[i] = shadow_handle[i - 1];
      shadow_expiry[i] = shadow_expiry[i - 1];
    end
    shadow_handle[pos] = h;
    shadow_expiry[pos] = t;
    shadow_count++;
  endtask

  task automatic apply_timer_op(input logic [KIND_W-1:0] k, input logic [HANDLE_W-1:0] h,
                                input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] now);
    int pos;
    int n;
    logic [STATUS_W-1:0] st;
    outcome_t o;
    if (k == KIND_TICK) begin
      n = 0;
      while (n < MAX_RESULTS && shadow_count > 0 && shadow_expiry[0] <= now) begin
        o.handle = shadow_handle[0];
        o.expired = 1'b1;
        o.status = STATUS_OK;
        drop_entry(0);
        n++;
        o.last = (n == MAX_RESULTS) || (shadow_count == 0) || (shadow_expiry[0] > now);
        outcome_q.push_back(o);
      end
      if (n == 0) begin
        o = '{handle: '0, expired: 1'b0, status: STATUS_OK, last: 1'b1};
        outcome_q.push_back(o);
      end
    end else begin
      pos = -1;
      for (int i = 0; i < shadow_count; i++) begin
        if (pos < 0 && shadow_handle[i] == h) pos = i;
      end
      st = STATUS_OK;
      if (k == KIND_ADD) begin
        if (pos >= 0) st = STATUS_DUPLICATE;
        else if (shadow_count >= CAP) st = STATUS_FULL;
        else place_entry(h, t);
      end else if (pos < 0) begin
        st = STATUS_NOT_FOUND;
      end else begin
        drop_entry(pos);
        if (k == KIND_ADJUST) place_entry(h, t);
      end
      o = '{handle: '0, expired: 1'b0, status: st, last: 1'b1};
      outcome_q.push_back(o);
    end
  endtask

  task automatic send_word(input logic [KIND_W-1:0] k, input logic [HANDLE_W-1:0] h,
                           input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] now);
    int gap;
    in_valid <= 1'b1;
    kind <= k;
    timer_handle <= h;
    expiry_time <= t;
    now_time <= now;
    do @(posedge clk); while (in_stall !== 1'b0);
    apply_timer_op(k, h, t, now);
    words_sent++;
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got handle %0d status %0d",
                 $time, expired_handle, status);
        errors++;
      end else begin
        oldest = outcome_q.pop_front();
        compare_field("expired_handle", 32'(oldest.handle), 32'(expired_handle));
        compare_field("has_expired", 32'(oldest.expired), 32'(has_expired));
        compare_field("status", 32'(oldest.status), 32'(status));
        compare_field("last_of_run", 32'(oldest.last), 32'(last_of_run));
        results_seen++;
        if (oldest.expired) expired_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (free_left > 0) begin
          free_left--;
        end else begin
          stall_left = idle_len();
          free_left = $urandom_range(0, 8);
        end
      end
    end
  end

  task automatic test_basic();
    send_word(KIND_TICK, 8'h00, 32'h0, 32'h0);
    send_word(KIND_ADD, 8'h00, 32'h0, 32'hFFFF_FFFF);
    send_word(KIND_ADD, 8'hFF, 32'hFFFF_FFFF, 32'h0);
    send_word(KIND_ADD, 8'h00, 32'd5, 32'h0);
    send_word(KIND_ADD, 8'hA5, 32'd100, 32'h0);
    send_word(KIND_ADD, 8'h5A, 32'd100, 32'h0);
    send_word(KIND_ADJUST, 8'hFF, 32'd50, 32'h0);
    send_word(KIND_ADJUST, 8'h00, 32'd200, 32'h0);
    send_word(KIND_ADJUST, 8'h33, 32'd10, 32'h0);
    send_word(KIND_DELETE, 8'h77, 32'h0, 32'h0);
    send_word(KIND_DELETE, 8'h5A, 32'h0, 32'h0);
    send_word(KIND_TICK, 8'h00, 32'h0, 32'd49);
    send_word(KIND_TICK, 8'hFF, 32'hFFFF_FFFF, 32'd100);
    send_word(KIND_TICK, 8'h00, 32'h0, 32'hFFFF_FFFF);
  endtask

  task automatic test_full_store();
    for (int i = 0; i < CAP; i++) begin
      send_word(KIND_ADD, 8'h10 + i[7:0], (i % 4) * 1000, $urandom);
    end
    send_word(KIND_ADD, 8'hF0, 32'd7, 32'h0);
    send_word(KIND_ADD, 8'h10, 32'd7, 32'h0);
    send_word(KIND_DELETE, 8'hF1, 32'h0, 32'h0);
    send_word(KIND_TICK, 8'h00, 32'h0, 32'hFFFF_FFFF);
  endtask

  function automatic logic [HANDLE_W-1:0] pick_handle();
    if ($urandom_range(0, 99) < 75) return handle_pool[$urandom_range(0, POOL_SIZE - 1)];
    return HANDLE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [TIME_W-1:0] pick_expiry();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return time_cursor + $urandom_range(0, 300);
    if (r < 85) return recent_expiry;
    return $urandom;
  endfunction

  task automatic test_random_traffic(input int count);
    int r;
    logic [KIND_W-1:0] k;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] now;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 38) k = KIND_ADD;
      else if (r < 56) k = KIND_ADJUST;
      else if (r < 70) k = KIND_DELETE;
      else k = KIND_TICK;
      t = (k == KIND_ADD || k == KIND_ADJUST) ? pick_expiry() : $urandom;
      if (k == KIND_ADD || k == KIND_ADJUST) recent_expiry = t;
      now = $urandom;
      if (k == KIND_TICK) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          time_cursor = time_cursor + $urandom_range(0, 120);
          now = time_cursor;
        end else if (r < 85) begin
          now = time_cursor - $urandom_range(0, 50);
        end
      end
      send_word(k, pick_handle(), t, now);
    end
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_traffic(40);
    no_idle = 1'b0;
  endtask

  task automatic test_output_backpressure();
    hold_req = 1'b1;
    no_idle = 1'b1;
    test_random_traffic(40);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < POOL_SIZE; i++) handle_pool[i] = HANDLE_W'($urandom_range(0, 255));
    test_basic();
    wait_drained();
    test_full_store();
    wait_drained();
    test_random_traffic(70);
    test_back_to_back();
    wait_drained();
    test_output_backpressure();
    wait_drained();
    test_random_traffic(70);
    wait_drained();
    $display("Sent %0d words of adds, adjusts, deletes and ticks; checked %0d result words,",
             words_sent, results_seen);
    $display("%0d of them expired timers, under random gaps and a long output stall.",
             expired_seen);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
